FILE: design/query_string_pair_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef QUERY_STRING_PAIR_DECODER_MACROS_SVH
`define QUERY_STRING_PAIR_DECODER_MACROS_SVH

// Check on every edge with reset ignored.
`define QSPD_ASSERT_NORST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on every edge outside reset.
`define QSPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

FILE: design/qspd_pkg.sv
package qspd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] result_kind;
		logic       run_end;
	} out_t;

	localparam logic [1:0] KIND_KEY      = 2'd0;
	localparam logic [1:0] KIND_VALUE    = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;
	localparam logic [1:0] KIND_DROPPED  = 2'd3;

	// One accepted byte's results: one or two words.
	typedef struct packed {
		logic two;
		out_t r0;
		out_t r1;
	} entry_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

FILE: design/query_string_pair_decoder.sv
// Percent-decoding splitter for URL query strings. One raw byte enters per cycle while
// full is low; each byte yields zero, one or two result words (key/value byte, pair
// complete or pair dropped), the last one flagged run_end. Results drain one word per
// cycle while pop is high from a four-entry queue of per-byte entries, so a byte that
// gives two words takes two pops and the input side keeps running until that queue
// fills. A byte's entry is registered into the queue ahead of the result port.
module query_string_pair_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  qspd_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output qspd_pkg::out_t result
);

	logic             entry_push;
	qspd_pkg::entry_t entry;
	qspd_pkg::entry_t head;
	logic             head_empty;
	logic             head_pop;

	qspd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.entry_push (entry_push),
		.entry      (entry)
	);

	qspd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (entry_push),
		.wdata  (entry),
		.full   (full),
		.rd     (head_pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	qspd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

FILE: design/qspd_front.sv
module qspd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  qspd_pkg::in_t    item,
	output logic             entry_push,
	output qspd_pkg::entry_t entry
);

	`include "query_string_pair_decoder_macros.svh"

	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [1:0] ESC_NONE  = 2'd0;
	localparam logic [1:0] ESC_PCT   = 2'd1;
	localparam logic [1:0] ESC_DIGIT = 2'd2;

	logic       val_q;
	logic [1:0] esc_q;
	logic [3:0] hi_q;
	logic       hv_q;

	logic       val_n;
	logic [1:0] esc_n;
	logic [3:0] hi_n;
	logic       hv_n;

	logic       accept;
	logic [7:0] b;
	logic       sep;
	logic       pend;
	logic       d_ok;
	logic [3:0] d_val;
	logic       p_valid;
	logic [7:0] p_byte;
	logic [1:0] p_kind;
	qspd_pkg::out_t mark;

	function automatic logic is_dec(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha_hex(input logic [7:0] c);
		return c inside {[8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	assign accept = push && !full;
	assign b      = item.in_byte;
	assign sep    = (b == CH_AMP) || (b == CH_EQ && !val_q);
	assign pend   = (esc_q == ESC_PCT) || (esc_q == ESC_DIGIT);
	assign d_ok   = is_dec(b) || is_alpha_hex(b);
	assign d_val  = is_dec(b) ? b[3:0] : b[3:0] + 4'd9;

	always_comb begin
		val_n   = val_q;
		esc_n   = esc_q;
		hi_n    = hi_q;
		hv_n    = hv_q;
		p_valid = 1'b0;
		p_byte  = b;
		p_kind  = val_q ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;
		if (pend && !sep) begin
			if (esc_q == ESC_PCT) begin
				hi_n  = d_ok ? d_val : 4'd0;
				hv_n  = d_ok;
				esc_n = ESC_DIGIT;
			end else begin
				p_valid = hv_q && d_ok;
				p_byte  = {hi_q, d_val};
				esc_n   = ESC_NONE;
				hi_n    = 4'd0;
				hv_n    = 1'b0;
			end
		end else if (b == CH_AMP) begin
			p_valid = 1'b1;
			p_byte  = 8'd0;
			p_kind  = val_q ? qspd_pkg::KIND_COMPLETE : qspd_pkg::KIND_DROPPED;
			val_n   = 1'b0;
			esc_n   = ESC_NONE;
			hi_n    = 4'd0;
			hv_n    = 1'b0;
		end else if (b == CH_EQ && !val_q) begin
			val_n = 1'b1;
			esc_n = ESC_NONE;
			hi_n  = 4'd0;
			hv_n  = 1'b0;
		end else if (b == CH_PCT) begin
			esc_n = ESC_PCT;
			hi_n  = 4'd0;
			hv_n  = 1'b0;
		end else begin
			p_valid = 1'b1;
			esc_n   = ESC_NONE;
			hi_n    = 4'd0;
			hv_n    = 1'b0;
		end

		// Close the segment on the last byte; state after a trailing '&' is key part.
		mark.out_byte    = 8'd0;
		mark.result_kind = val_n ? qspd_pkg::KIND_COMPLETE : qspd_pkg::KIND_DROPPED;
		mark.run_end     = 1'b1;
		if (item.final_byte) begin
			val_n = 1'b0;
			esc_n = ESC_NONE;
			hi_n  = 4'd0;
			hv_n  = 1'b0;
		end

		entry.two = p_valid && item.final_byte;
		entry.r1  = mark;
		if (p_valid) begin
			entry.r0.out_byte    = p_byte;
			entry.r0.result_kind = p_kind;
			entry.r0.run_end     = !item.final_byte;
		end else begin
			entry.r0 = mark;
		end
		entry_push = accept && (p_valid || item.final_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
			esc_q <= ESC_NONE;
			hi_q  <= 4'd0;
			hv_q  <= 1'b0;
		end else if (accept) begin
			val_q <= val_n;
			esc_q <= esc_n;
			hi_q  <= hi_n;
			hv_q  <= hv_n;
		end
	end

	`QSPD_ASSERT(a_final_clears, (accept && item.final_byte) |=> (!val_q && esc_q == ESC_NONE && !hv_q), "state not cleared after last byte")
	`QSPD_ASSERT(a_esc_legal, (esc_q != 2'd3), "escape counter reached three")

endmodule

FILE: design/qspd_fifo.sv
module qspd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  qspd_pkg::entry_t wdata,
	output logic             full,
	input  logic             rd,
	output qspd_pkg::entry_t rdata,
	output logic             empty
);

	`include "query_string_pair_decoder_macros.svh"

	localparam logic [qspd_pkg::FIFO_AW:0] DEPTH_C =
		(qspd_pkg::FIFO_AW + 1)'(qspd_pkg::FIFO_DEPTH);

	qspd_pkg::entry_t             mem_q [qspd_pkg::FIFO_DEPTH];
	logic [qspd_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [qspd_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [qspd_pkg::FIFO_AW:0]   count_q;
	logic                         wr_ok;
	logic                         rd_ok;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_ok && !rd_ok) begin
				count_q <= count_q + 1'b1;
			end else if (rd_ok && !wr_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`QSPD_ASSERT_NORST(a_count_bound, (count_q <= DEPTH_C), "queue count above depth")

endmodule

FILE: design/qspd_back.sv
module qspd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  qspd_pkg::entry_t head,
	input  logic             head_empty,
	output logic             head_pop,
	input  logic             pop,
	output logic             empty,
	output qspd_pkg::out_t   result
);

	`include "query_string_pair_decoder_macros.svh"

	// Set while the second word of the head entry is on show.
	logic idx_q;
	logic take;

	assign empty    = head_empty;
	assign take     = pop && !head_empty;
	assign result   = idx_q ? head.r1 : head.r0;
	assign head_pop = take && (idx_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (take) begin
			idx_q <= !head_pop;
		end
	end

	`QSPD_ASSERT(a_second_has_head, idx_q |-> (!head_empty && head.two), "second word without a two-word head")

endmodule
